>>> design/aed_pkg.sv
package aed_pkg;

    localparam int unsigned DATA_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_SUSPECT = 2'd1,
        MODE_ACTIVE  = 2'd2,
        MODE_DECAY   = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PM_START   = 8'd0,
        REG_VOC_START  = 8'd1,
        REG_PM_ACTIVE  = 8'd2,
        REG_VOC_ACTIVE = 8'd3,
        REG_PM_END     = 8'd4,
        REG_VOC_END    = 8'd5,
        REG_PM_QUIET   = 8'd6,
        REG_VOC_QUIET  = 8'd7
    } reg_index_t;

    localparam logic signed [DATA_W-1:0] PM_START_RST   = 16'sd50;
    localparam logic signed [DATA_W-1:0] VOC_START_RST  = 16'sd50;
    localparam logic signed [DATA_W-1:0] PM_ACTIVE_RST  = 16'sd100;
    localparam logic signed [DATA_W-1:0] VOC_ACTIVE_RST = 16'sd100;
    localparam logic signed [DATA_W-1:0] PM_END_RST     = 16'sd20;
    localparam logic signed [DATA_W-1:0] VOC_END_RST    = 16'sd20;
    localparam logic signed [DATA_W-1:0] PM_QUIET_RST   = 16'sd10;
    localparam logic signed [DATA_W-1:0] VOC_QUIET_RST  = 16'sd10;

    typedef struct packed {
        logic signed [DATA_W-1:0] pm_start_level;
        logic signed [DATA_W-1:0] voc_start_level;
        logic signed [DATA_W-1:0] pm_active_level;
        logic signed [DATA_W-1:0] voc_active_level;
        logic signed [DATA_W-1:0] pm_end_level;
        logic signed [DATA_W-1:0] voc_end_level;
        logic signed [DATA_W-1:0] pm_quiet_level;
        logic signed [DATA_W-1:0] voc_quiet_level;
    } thresholds_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pm_spike;
        logic signed [DATA_W-1:0] voc_jump;
        logic [DATA_W-1:0]        pm_level;
        logic [DATA_W-1:0]        voc_level;
        logic [DATA_W-1:0]        nox_level;
    } sample_t;

    typedef struct packed {
        mode_t             mode;
        logic [DATA_W-1:0] length;
        logic [DATA_W-1:0] top_pm;
        logic [DATA_W-1:0] top_voc;
        logic [DATA_W-1:0] top_nox;
    } event_state_t;

endpackage

>>> design/aed_sample_if.sv
interface aed_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [aed_pkg::DATA_W-1:0]   pm_spike;
    logic signed [aed_pkg::DATA_W-1:0]   voc_jump;
    logic [aed_pkg::DATA_W-1:0]          pm_level;
    logic [aed_pkg::DATA_W-1:0]          voc_level;
    logic [aed_pkg::DATA_W-1:0]          nox_level;

    modport source (
        output valid, pm_spike, voc_jump, pm_level, voc_level, nox_level,
        input  ready
    );

    modport sink (
        input  valid, pm_spike, voc_jump, pm_level, voc_level, nox_level,
        output ready
    );
endinterface

>>> design/aed_result_if.sv
interface aed_result_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   event_mode;
    logic [aed_pkg::DATA_W-1:0]   event_length;
    logic [aed_pkg::DATA_W-1:0]   max_pm;
    logic [aed_pkg::DATA_W-1:0]   max_voc;
    logic [aed_pkg::DATA_W-1:0]   max_nox;

    modport source (
        output valid, event_mode, event_length, max_pm, max_voc, max_nox,
        input  ready
    );

    modport sink (
        input  valid, event_mode, event_length, max_pm, max_voc, max_nox,
        output ready
    );
endinterface

>>> design/air_event_detector_core.sv
// Air-quality event detector. Each sample transfer on the sample channel
// produces exactly one result transfer carrying the event state (idle,
// suspect, active, decay), the saturating event length and the peak
// particle, VOC and NOx levels as they stand after that sample. A sample
// is captured in an input register and evaluated into the result register
// once the result side is free; the block takes one sample per clock cycle
// while the result side does not stall. The result register also holds
// the event state, so a stalled result stalls the evaluation stage. The user
// must write thresholds through the configuration port only while no sample
// is in flight; the block does not enforce it. Peaks are cleared only by reset.
module air_event_detector_core (
    input  logic                           clk,
    input  logic                           rst_n,
    aed_sample_if.sink                     sample,
    aed_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [aed_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aed_pkg::DATA_W-1:0]     cfg_data
);

    aed_pkg::thresholds_t  thr_reg;
    aed_pkg::sample_t      s1_data_reg;
    logic                  s1_valid_reg;
    aed_pkg::event_state_t state_reg;
    aed_pkg::event_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_free;
    logic                  advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.pm_start_level   <= aed_pkg::PM_START_RST;
            thr_reg.voc_start_level  <= aed_pkg::VOC_START_RST;
            thr_reg.pm_active_level  <= aed_pkg::PM_ACTIVE_RST;
            thr_reg.voc_active_level <= aed_pkg::VOC_ACTIVE_RST;
            thr_reg.pm_end_level     <= aed_pkg::PM_END_RST;
            thr_reg.voc_end_level    <= aed_pkg::VOC_END_RST;
            thr_reg.pm_quiet_level   <= aed_pkg::PM_QUIET_RST;
            thr_reg.voc_quiet_level  <= aed_pkg::VOC_QUIET_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aed_pkg::REG_PM_START:   thr_reg.pm_start_level   <= cfg_data;
                aed_pkg::REG_VOC_START:  thr_reg.voc_start_level  <= cfg_data;
                aed_pkg::REG_PM_ACTIVE:  thr_reg.pm_active_level  <= cfg_data;
                aed_pkg::REG_VOC_ACTIVE: thr_reg.voc_active_level <= cfg_data;
                aed_pkg::REG_PM_END:     thr_reg.pm_end_level     <= cfg_data;
                aed_pkg::REG_VOC_END:    thr_reg.voc_end_level    <= cfg_data;
                aed_pkg::REG_PM_QUIET:   thr_reg.pm_quiet_level   <= cfg_data;
                aed_pkg::REG_VOC_QUIET:  thr_reg.voc_quiet_level  <= cfg_data;
                default:
                begin
                    thr_reg <= thr_reg;
                end
            endcase
        end
    end

    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = s1_valid_reg && out_free;
    assign sample.ready = !s1_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            s1_data_reg.pm_spike  <= sample.pm_spike;
            s1_data_reg.voc_jump  <= sample.voc_jump;
            s1_data_reg.pm_level  <= sample.pm_level;
            s1_data_reg.voc_level <= sample.voc_level;
            s1_data_reg.nox_level <= sample.nox_level;
        end
    end

    aed_step u_step (
        .thr (thr_reg),
        .smp (s1_data_reg),
        .cur (state_reg),
        .nxt (state_next)
    );

    // Event state doubles as the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode    <= aed_pkg::MODE_IDLE;
            state_reg.length  <= '0;
            state_reg.top_pm  <= '0;
            state_reg.top_voc <= '0;
            state_reg.top_nox <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.event_mode   = state_reg.mode;
    assign result.event_length = state_reg.length;
    assign result.max_pm       = state_reg.top_pm;
    assign result.max_voc      = state_reg.top_voc;
    assign result.max_nox      = state_reg.top_nox;

    // Idle can only be left toward suspect.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == aed_pkg::MODE_IDLE) |=>
            (state_reg.mode == aed_pkg::MODE_IDLE ||
             state_reg.mode == aed_pkg::MODE_SUSPECT))
    else $error("event state left idle toward something other than suspect");

    // A new event starts with a cleared length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == aed_pkg::MODE_IDLE) ##1
            (state_reg.mode == aed_pkg::MODE_SUSPECT) |-> (state_reg.length == '0))
    else $error("event length not cleared on entering suspect");

    // Peaks never decrease outside reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (state_reg.top_pm  >= $past(state_reg.top_pm) &&
                  state_reg.top_voc >= $past(state_reg.top_voc) &&
                  state_reg.top_nox >= $past(state_reg.top_nox)))
    else $error("a peak level decreased");

    // A captured sample waits until the result side can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=>
            (s1_valid_reg && $stable(s1_data_reg) && $stable(state_reg)))
    else $error("pending sample lost or state changed during a stall");

endmodule

>>> design/aed_step.sv
module aed_step (
    input  aed_pkg::thresholds_t  thr,
    input  aed_pkg::sample_t      smp,
    input  aed_pkg::event_state_t cur,
    output aed_pkg::event_state_t nxt
);

    logic                       ended;
    logic                       quiet;
    logic                       start_hit;
    logic                       active_hit;
    logic [aed_pkg::DATA_W-1:0] length_inc;

    assign ended      = (smp.pm_spike < thr.pm_end_level) &&
                        (smp.voc_jump < thr.voc_end_level);
    assign quiet      = (smp.pm_spike < thr.pm_quiet_level) &&
                        (smp.voc_jump < thr.voc_quiet_level);
    assign start_hit  = (smp.pm_spike > thr.pm_start_level) ||
                        (smp.voc_jump > thr.voc_start_level);
    assign active_hit = (smp.pm_spike > thr.pm_active_level) ||
                        (smp.voc_jump > thr.voc_active_level);

    // The duration count holds at all ones instead of wrapping.
    assign length_inc = (&cur.length) ? cur.length : cur.length + 1'b1;

    always_comb
    begin
        nxt = cur;
        unique case (cur.mode)
            aed_pkg::MODE_IDLE:
            begin
                if (start_hit)
                begin
                    nxt.mode   = aed_pkg::MODE_SUSPECT;
                    nxt.length = '0;
                end
            end
            aed_pkg::MODE_SUSPECT:
            begin
                nxt.length = length_inc;
                // Falling back to idle wins over escalating to active.
                priority if (ended)
                    nxt.mode = aed_pkg::MODE_IDLE;
                else if (active_hit)
                    nxt.mode = aed_pkg::MODE_ACTIVE;
            end
            aed_pkg::MODE_ACTIVE:
            begin
                nxt.length = length_inc;
                if (smp.pm_level > cur.top_pm)
                    nxt.top_pm = smp.pm_level;
                if (smp.voc_level > cur.top_voc)
                    nxt.top_voc = smp.voc_level;
                if (smp.nox_level > cur.top_nox)
                    nxt.top_nox = smp.nox_level;
                if (ended)
                    nxt.mode = aed_pkg::MODE_DECAY;
            end
            aed_pkg::MODE_DECAY:
            begin
                if (quiet)
                    nxt.mode = aed_pkg::MODE_IDLE;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_REGS  = 8;
    localparam int DATA_W    = aed_pkg::DATA_W;
    localparam int CFG_IDX_W = aed_pkg::CFG_IDX_W;

    localparam aed_pkg::thresholds_t RESET_THR = '{
        aed_pkg::PM_START_RST, aed_pkg::VOC_START_RST,
        aed_pkg::PM_ACTIVE_RST, aed_pkg::VOC_ACTIVE_RST,
        aed_pkg::PM_END_RST, aed_pkg::VOC_END_RST,
        aed_pkg::PM_QUIET_RST, aed_pkg::VOC_QUIET_RST
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    aed_sample_if sample_ch ();
    aed_result_if result_ch ();

    air_event_detector_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted detector state and thresholds.
    aed_pkg::thresholds_t thr = RESET_THR;
    aed_pkg::mode_t       ev_mode = aed_pkg::MODE_IDLE;
    logic [DATA_W-1:0]    ev_length = '0;
    logic [DATA_W-1:0]    top_pm = '0;
    logic [DATA_W-1:0]    top_voc = '0;
    logic [DATA_W-1:0]    top_nox = '0;

    aed_pkg::event_state_t expected_states[$];
    int           mismatches = 0;
    int           results_checked = 0;
    int           settings_loaded = 0;
    bit           idle_on = 1'b1;
    int unsigned  level_cap = 255;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[air_event_detector_core] ERROR");
        $finish;
    end

    function automatic aed_pkg::event_state_t step_event(aed_pkg::sample_t s);
        aed_pkg::event_state_t r;
        logic                  ended;
        logic [DATA_W-1:0]     counted;
        ended = ($signed(s.pm_spike) < $signed(thr.pm_end_level)) &&
                ($signed(s.voc_jump) < $signed(thr.voc_end_level));
        counted = (ev_length == '1) ? ev_length : ev_length + 1'b1;
        case (ev_mode)
            aed_pkg::MODE_IDLE:
            begin
                if ($signed(s.pm_spike) > $signed(thr.pm_start_level) ||
                    $signed(s.voc_jump) > $signed(thr.voc_start_level))
                begin
                    ev_mode   = aed_pkg::MODE_SUSPECT;
                    ev_length = '0;
                end
            end
            aed_pkg::MODE_SUSPECT:
            begin
                ev_length = counted;
                // Ending the event wins over escalating it.
                if (ended)
                    ev_mode = aed_pkg::MODE_IDLE;
                else if ($signed(s.pm_spike) > $signed(thr.pm_active_level) ||
                         $signed(s.voc_jump) > $signed(thr.voc_active_level))
                    ev_mode = aed_pkg::MODE_ACTIVE;
            end
            aed_pkg::MODE_ACTIVE:
            begin
                ev_length = counted;
                if (s.pm_level > top_pm)
                    top_pm = s.pm_level;
                if (s.voc_level > top_voc)
                    top_voc = s.voc_level;
                if (s.nox_level > top_nox)
                    top_nox = s.nox_level;
                if (ended)
                    ev_mode = aed_pkg::MODE_DECAY;
            end
            default:
            begin
                if ($signed(s.pm_spike) < $signed(thr.pm_quiet_level) &&
                    $signed(s.voc_jump) < $signed(thr.voc_quiet_level))
                    ev_mode = aed_pkg::MODE_IDLE;
            end
        endcase
        r.mode    = ev_mode;
        r.length  = ev_length;
        r.top_pm  = top_pm;
        r.top_voc = top_voc;
        r.top_nox = top_nox;
        return r;
    endfunction

    function automatic aed_pkg::sample_t sample_of(int pm, int voc, int pml, int vocl,
                                                   int noxl);
        aed_pkg::sample_t s;
        s.pm_spike  = DATA_W'(pm);
        s.voc_jump  = DATA_W'(voc);
        s.pm_level  = DATA_W'(pml);
        s.voc_level = DATA_W'(vocl);
        s.nox_level = DATA_W'(noxl);
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] threshold_at(int unsigned i);
        return thr[(NUM_REGS - 1 - i) * DATA_W +: DATA_W];
    endfunction

    // Threshold plus a random offset in [lo, hi], clamped to the signed range.
    function automatic logic [DATA_W-1:0] offset_level(logic signed [DATA_W-1:0] lvl,
                                                       int lo, int hi);
        int v;
        v = lvl + lo + int'($urandom_range(hi - lo));
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return DATA_W'(v);
    endfunction

    // Most samples push the event toward its next state so that long episodes
    // occur; the rest sit near a threshold or are plain noise.
    function automatic aed_pkg::sample_t make_sample();
        aed_pkg::sample_t s;
        int unsigned      roll;
        int unsigned      k;
        roll = $urandom_range(9);
        s.pm_level  = DATA_W'($urandom_range(level_cap));
        s.voc_level = DATA_W'($urandom_range(level_cap));
        s.nox_level = DATA_W'($urandom_range(level_cap));
        s.pm_spike  = offset_level(threshold_at($urandom_range(NUM_REGS - 1)), -4, 4);
        s.voc_jump  = offset_level(threshold_at($urandom_range(NUM_REGS - 1)), -4, 4);
        if (roll < 2)
        begin
            s.pm_spike = DATA_W'($urandom);
            s.voc_jump = DATA_W'($urandom);
        end
        else if (roll < 8)
        begin
            case (ev_mode)
                aed_pkg::MODE_IDLE:
                begin
                    if ($urandom_range(1))
                        s.pm_spike = offset_level(thr.pm_start_level, 1, 40);
                    else
                        s.voc_jump = offset_level(thr.voc_start_level, 1, 40);
                end
                aed_pkg::MODE_SUSPECT:
                begin
                    k = $urandom_range(3);
                    if (k == 0)
                        s.pm_spike = offset_level(thr.pm_active_level, 1, 40);
                    else if (k == 1)
                        s.voc_jump = offset_level(thr.voc_active_level, 1, 40);
                    else if (k == 2)
                    begin
                        s.pm_spike = offset_level(thr.pm_end_level, -40, -1);
                        s.voc_jump = offset_level(thr.voc_end_level, -40, -1);
                    end
                end
                aed_pkg::MODE_ACTIVE:
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        s.pm_spike = offset_level(thr.pm_end_level, -40, -1);
                        s.voc_jump = offset_level(thr.voc_end_level, -40, -1);
                    end
                    else
                        s.pm_spike = offset_level(thr.pm_end_level, 0, 40);
                end
                default:
                begin
                    s.pm_spike = offset_level(thr.pm_quiet_level, -40, -1);
                    s.voc_jump = offset_level(thr.voc_quiet_level, -40, -1);
                end
            endcase
        end
        return s;
    endfunction

    function automatic aed_pkg::thresholds_t make_thresholds(bit ordered);
        aed_pkg::thresholds_t t;
        int                   base;
        int unsigned          k;
        if (ordered)
        begin
            // quiet <= end <= start <= active on each side
            base = int'($urandom_range(600)) - 300;
            t.pm_quiet_level  = DATA_W'(base);
            t.pm_end_level    = DATA_W'(base + int'($urandom_range(60)));
            t.pm_start_level  = t.pm_end_level + DATA_W'($urandom_range(60));
            t.pm_active_level = t.pm_start_level + DATA_W'($urandom_range(60));
            base = int'($urandom_range(600)) - 300;
            t.voc_quiet_level  = DATA_W'(base);
            t.voc_end_level    = DATA_W'(base + int'($urandom_range(60)));
            t.voc_start_level  = t.voc_end_level + DATA_W'($urandom_range(60));
            t.voc_active_level = t.voc_start_level + DATA_W'($urandom_range(60));
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                k = $urandom_range(7);
                t[(NUM_REGS - 1 - i) * DATA_W +: DATA_W] =
                    (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 : DATA_W'($urandom);
            end
        end
        return t;
    endfunction

    function automatic int pick_gap();
        if (!idle_on || $urandom_range(3) != 0)
            return 0;
        return $urandom_range(10, 1);
    endfunction

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Valid is left high after a transfer so back-to-back samples never
    // toggle it within one time step.
    task automatic send_sample(aed_pkg::sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.pm_spike  <= s.pm_spike;
        sample_ch.voc_jump  <= s.voc_jump;
        sample_ch.pm_level  <= s.pm_level;
        sample_ch.voc_level <= s.voc_level;
        sample_ch.nox_level <= s.nox_level;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        expected_states.push_back(step_event(s));
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (expected_states.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            aed_pkg::REG_PM_START:   thr.pm_start_level   = val;
            aed_pkg::REG_VOC_START:  thr.voc_start_level  = val;
            aed_pkg::REG_PM_ACTIVE:  thr.pm_active_level  = val;
            aed_pkg::REG_VOC_ACTIVE: thr.voc_active_level = val;
            aed_pkg::REG_PM_END:     thr.pm_end_level     = val;
            aed_pkg::REG_VOC_END:    thr.voc_end_level    = val;
            aed_pkg::REG_PM_QUIET:   thr.pm_quiet_level   = val;
            aed_pkg::REG_VOC_QUIET:  thr.voc_quiet_level  = val;
            default:                 ;
        endcase
    endtask

    // Struct fields are packed in register index order, first field on top.
    task automatic load_thresholds(aed_pkg::thresholds_t t);
        for (int i = 0; i < NUM_REGS; i++)
            write_cfg(CFG_IDX_W'(i), t[(NUM_REGS - 1 - i) * DATA_W +: DATA_W]);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic test_state_walk();
        send_sample(sample_of(50, 50, 65535, 65535, 65535));
        send_sample(sample_of(-32768, -32768, 0, 0, 0));
        send_sample(sample_of(51, 0, 3, 3, 3));
        send_sample(sample_of(100, 20, 4, 4, 4));
        send_sample(sample_of(0, 101, 300, 40, 12));
        send_sample(sample_of(32767, 32767, 800, 500, 90));
        send_sample(sample_of(19, 19, 200, 100, 10));
        send_sample(sample_of(10, -5, 9, 9, 9));
        send_sample(sample_of(9, 9, 9, 9, 9));
        send_sample(sample_of(0, 51, 1, 1, 1));
        send_sample(sample_of(19, 19, 1, 1, 1));
        send_sample(sample_of(32767, 0, 2, 2, 2));
        send_sample(sample_of(0, 32767, 2, 2, 2));
        // A new event must not clear the peaks of the previous one.
        send_sample(sample_of(50, 50, 5, 5, 5));
        send_sample(sample_of(-32768, -32768, 6, 6, 6));
        send_sample(sample_of(-32768, -32768, 6, 6, 6));
        drain_results();
    endtask

    task automatic test_unknown_index();
        write_cfg(CFG_IDX_W'(NUM_REGS), 16'h8000);
        write_cfg({CFG_IDX_W{1'b1}}, 16'h8000);
        write_cfg(CFG_IDX_W'($urandom_range(254, NUM_REGS)), 16'h8000);
        cfg_we <= 1'b0;
        send_sample(sample_of(50, 50, 0, 0, 0));
        send_sample(sample_of(51, 0, 0, 0, 0));
        send_sample(sample_of(-32768, -32768, 0, 0, 0));
        drain_results();
    endtask

    task automatic test_end_priority();
        aed_pkg::thresholds_t t;
        t = RESET_THR;
        t.pm_end_level  = 16'sd200;
        t.voc_end_level = 16'sd200;
        load_thresholds(t);
        send_sample(sample_of(60, 0, 7, 7, 7));
        send_sample(sample_of(150, 150, 7, 7, 7));
        send_sample(sample_of(60, 0, 7, 7, 7));
        send_sample(sample_of(250, 0, 8, 8, 8));
        send_sample(sample_of(0, 0, 8, 8, 8));
        send_sample(sample_of(0, 0, 8, 8, 8));
        drain_results();
    endtask

    task automatic test_long_event();
        idle_on = 1'b0;
        load_thresholds(RESET_THR);
        repeat (200)
            send_sample(sample_of(32767, 0, $urandom_range(15), $urandom_range(15),
                                  $urandom_range(15)));
        send_sample(sample_of(-32768, -32768, 0, 0, 0));
        send_sample(sample_of(-32768, -32768, 0, 0, 0));
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_thresholds();
        aed_pkg::thresholds_t t;
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph > 0)
                drain_results();
            idle_on   = (ph < 10);
            level_cap = (1 << (ph + 5)) - 1;
            if (ph == 0)
                t = '{default: 16'sh7FFF};
            else if (ph == 1)
                t = '{default: 16'sh8000};
            else
                t = make_thresholds(ph % 2 == 0);
            load_thresholds(t);
            repeat (85)
                send_sample(make_sample());
        end
        drain_results();
    endtask

    // Result side: random stall bursts while idling is enabled.
    initial
    begin
        int hold;
        hold = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(4) == 0)
            begin
                hold = $urandom_range(9);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        aed_pkg::event_state_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (expected_states.size() == 0)
            begin
                $error("result transfer with no sample outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_states.pop_front();
                results_checked++;
                check_field("event_mode", DATA_W'(want.mode), DATA_W'(result_ch.event_mode));
                check_field("event_length", want.length, result_ch.event_length);
                check_field("max_pm", want.top_pm, result_ch.max_pm);
                check_field("max_voc", want.top_voc, result_ch.max_voc);
                check_field("max_nox", want.top_nox, result_ch.max_nox);
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        sample_ch.valid     = 1'b0;
        sample_ch.pm_spike  = '0;
        sample_ch.voc_jump  = '0;
        sample_ch.pm_level  = '0;
        sample_ch.voc_level = '0;
        sample_ch.nox_level = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_state_walk();
        test_unknown_index();
        test_end_priority();
        test_long_event();
        test_random_thresholds();

        repeat (8) @(posedge clk);
        if (expected_states.size() != 0)
            $error("%0d expected results never arrived", expected_states.size());
        $display("Checked %0d results under %0d threshold settings.",
                 results_checked, settings_loaded);
        $display("Covered all state moves, end priority, ignored indexes and a long event.");
        if (mismatches == 0 && expected_states.size() == 0)
            $display("[air_event_detector_core] OK");
        else
            $display("[air_event_detector_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
design/aed_pkg.sv
design/aed_sample_if.sv
design/aed_result_if.sv
design/aed_step.sv
design/air_event_detector_core.sv
verif/tb.sv
